// ----- hdl/lccs_pkg.sv -----
// ----------------------------------------------------------------------------
// lccs_pkg: shared types and constants
// Beat types, register indexes and status codes of the candidate selector.
// ----------------------------------------------------------------------------
package lccs_pkg;

	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int MAX_PICKS_DEF     = 16;

	localparam logic [2:0] CFG_CHECK_INTERVAL  = 3'd0;
	localparam logic [2:0] CFG_MIN_ID_SEP      = 3'd1;
	localparam logic [2:0] CFG_MIN_TIME_SEP    = 3'd2;
	localparam logic [2:0] CFG_MAX_PLANAR      = 3'd3;
	localparam logic [2:0] CFG_MAX_HEIGHT      = 3'd4;
	localparam logic [2:0] CFG_MIN_CAND_SEP    = 3'd5;
	localparam logic [2:0] CFG_MAX_CANDIDATES  = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TIME_REJ = 2'd1;
	localparam logic [1:0] ST_FULL_REJ = 2'd2;

	typedef struct packed {
		logic [47:0]        timestamp_us;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
	} in_t;

	typedef struct packed {
		logic [9:0]  kf_num;
		logic [9:0]  match_num;
		logic [9:0]  num_gap;
		logic [47:0] time_separation_us;
		logic [49:0] planar_distance_sq;
		logic [24:0] z_gap;
		logic [49:0] translation_distance_sq;
		logic        checked;
		logic [10:0] eligible_count;
		logic [10:0] nearby_count;
		logic [1:0]  status;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [47:0] ts;
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
	} hist_t;

endpackage

// ----- hdl/lccs_ram.sv -----
// ----------------------------------------------------------------------------
// lccs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/lccs_mul.sv -----
// ----------------------------------------------------------------------------
// lccs_mul: shared signed multiplier
// 25x25 signed multiply with a registered 50-bit product.
// ----------------------------------------------------------------------------
module lccs_mul (
	input  logic               clk,
	input  logic signed [24:0] a,
	input  logic signed [24:0] b,
	output logic [49:0]        p
);

	logic signed [49:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign p = prod_q;

endmodule

// ----- hdl/loop_closure_candidate_selector.sv -----
// ----------------------------------------------------------------------------
// loop_closure_candidate_selector: radius search with top-k pick suppression
// Each keyframe beat on in_* gets the next history number; a rejected one
// does not take it up. A searched keyframe gets a gating pass over the
// history (states G_RD to G_WR per entry, through the shared multiplier),
// then one selection scan per pick, ending early on a scan that finds none.
// Result beats leave on out_*: one per pick, then a summary beat with last
// set. A rejected keyframe gets its summary beat from DECIDE, an unsearched
// one from SUM, which follows DECIDE. One keyframe is in flight at a time:
// in_ready is low from acceptance until the summary beat is taken and, for
// a keyframe that is not rejected, the keyframe is stored.
// A stalled receiver simply holds the result register; the sequencer waits.
// Reset empties the history and loads default register values; no clearing
// pass is needed. Register writes on cfg_* are always taken (cfg_ready high)
// and must only occur while the block is idle.
// ----------------------------------------------------------------------------
module loop_closure_candidate_selector
	import lccs_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int MAX_PICKS     = MAX_PICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int IDW = $clog2(HISTORY_DEPTH + 1);
	localparam int PW  = $clog2(MAX_PICKS + 1);
	localparam int DW  = 51;

	typedef enum logic [4:0] {
		IDLE, DECIDE, RAD, RADW, G_RD, G_DIF, G_MX, G_MY, G_ACC, G_WR,
		SEL_INIT, S_START, S_SCAN, P_RD, P_DIF, P_MZ, P_OUT, SUM, WAIT, STORE
	} state_t;

	state_t state_q, ret_q;

	logic [9:0]  ci_q, mis_q, mcs_q;
	logic [31:0] mts_q;
	logic [23:0] mpd_q, mhd_q;
	logic [4:0]  mc_q;

	in_t             cur_q;
	logic [IDW-1:0]  count_q, last_chk_q, i_q, elig_q, near_q;
	logic            has_chk_q, chk_q;
	logic [47:0]     last_time_q, rad2_q, tgap_q;
	logic signed [24:0] dx_q, dy_q, dz_q;
	logic [24:0]     hd_q;
	logic [49:0]     pd_q, bd_q, last_d_q;
	logic            elig_ok_q, found_q, have_last_q, v_s1;
	logic [AW-1:0]   best_q, last_i_q, idx_s1;
	logic [PW-1:0]   npick_q, limit_q;
	logic [AW-1:0]   chosen_q [MAX_PICKS];
	out_t            out_q;
	logic            out_v_q;

	hist_t           hist_rd, hist_wd;
	logic            hist_we;
	logic [AW-1:0]   hist_ra;
	logic [DW-1:0]   dist_rd, dist_wd;
	logic            dist_we;
	logic signed [24:0] mul_a;
	logic [49:0]     mul_p;

	logic signed [24:0] hx, hy, hz, cx, cy, cz, dz_c;
	logic [IDW-1:0]  id_gap;
	logic [47:0]     t_gap;
	logic            sup, later_ok, take, near_c;
	logic [49:0]     d_s;
	logic [AW-1:0]   gap_k;

	function automatic out_t summary_beat(input logic [9:0] num, input logic chk,
			input logic [10:0] elig, input logic [10:0] nearc, input logic [1:0] st);
		out_t b;
		b = '0;
		b.kf_num         = num;
		b.checked        = chk;
		b.eligible_count = elig;
		b.nearby_count   = nearc;
		b.status         = st;
		b.last           = 1'b1;
		return b;
	endfunction

	lccs_ram #(.WIDTH($bits(hist_t)), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk(clk), .we(hist_we), .waddr(count_q[AW-1:0]), .wdata(hist_wd),
		.raddr(hist_ra), .rdata(hist_rd)
	);

	lccs_ram #(.WIDTH(DW), .DEPTH(HISTORY_DEPTH)) u_dist (
		.clk(clk), .we(dist_we), .waddr(i_q[AW-1:0]), .wdata(dist_wd),
		.raddr(i_q[AW-1:0]), .rdata(dist_rd)
	);

	lccs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_a), .p(mul_p));

	assign in_ready  = (state_q == IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q  <= 10'd1;
			mis_q <= 10'd50;
			mts_q <= 32'd30000000;
			mpd_q <= 24'd10240;
			mhd_q <= 24'd2048;
			mcs_q <= 10'd10;
			mc_q  <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHECK_INTERVAL: ci_q  <= cfg_data[9:0];
				CFG_MIN_ID_SEP:     mis_q <= cfg_data[9:0];
				CFG_MIN_TIME_SEP:   mts_q <= cfg_data;
				CFG_MAX_PLANAR:     mpd_q <= cfg_data[23:0];
				CFG_MAX_HEIGHT:     mhd_q <= cfg_data[23:0];
				CFG_MIN_CAND_SEP:   mcs_q <= cfg_data[9:0];
				CFG_MAX_CANDIDATES: mc_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		hx = {hist_rd.x[23], hist_rd.x};
		hy = {hist_rd.y[23], hist_rd.y};
		hz = {hist_rd.z[23], hist_rd.z};
		cx = {cur_q.pos_x[23], cur_q.pos_x};
		cy = {cur_q.pos_y[23], cur_q.pos_y};
		cz = {cur_q.pos_z[23], cur_q.pos_z};
		dz_c = cz - hz;
		id_gap = count_q - i_q;
		t_gap = cur_q.timestamp_us - hist_rd.ts;
		near_c = elig_ok_q && (pd_q <= {2'b00, rad2_q}) && (hd_q <= {1'b0, mhd_q});

		hist_ra = (state_q == P_RD) ? best_q : i_q[AW-1:0];
		hist_we = (state_q == STORE);
		hist_wd.ts = cur_q.timestamp_us;
		hist_wd.x  = cur_q.pos_x;
		hist_wd.y  = cur_q.pos_y;
		hist_wd.z  = cur_q.pos_z;
		dist_we = (state_q == G_WR);
		dist_wd = {near_c, pd_q};

		case (state_q)
			RAD:     mul_a = {1'b0, mpd_q};
			G_MX:    mul_a = dx_q;
			G_MY:    mul_a = dy_q;
			P_MZ:    mul_a = dz_q;
			default: mul_a = dx_q;
		endcase

		d_s = dist_rd[49:0];
		later_ok = !have_last_q || (d_s > last_d_q) ||
			((d_s == last_d_q) && (idx_s1 > last_i_q));
		sup = 1'b0;
		for (int k = 0; k < MAX_PICKS; k++) begin
			gap_k = (chosen_q[k] > idx_s1) ? chosen_q[k] - idx_s1 : idx_s1 - chosen_q[k];
			if ((32'(k) < 32'(npick_q)) && (32'(gap_k) < 32'(mcs_q))) begin
				sup = 1'b1;
			end
		end
		take = v_s1 && dist_rd[50] && later_ok && !sup && (!found_q || d_s < bd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			ret_q       <= IDLE;
			count_q     <= '0;
			last_chk_q  <= '0;
			has_chk_q   <= 1'b0;
			out_v_q     <= 1'b0;
			v_s1        <= 1'b0;
			last_time_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						cur_q   <= in_data;
						state_q <= DECIDE;
					end
				end
				DECIDE: begin
					elig_q      <= '0;
					near_q      <= '0;
					chk_q       <= 1'b0;
					if (32'(count_q) == HISTORY_DEPTH) begin
						out_q   <= summary_beat(10'(count_q), 1'b0, '0, '0, ST_FULL_REJ);
						out_v_q <= 1'b1;
						ret_q   <= IDLE;
						state_q <= WAIT;
					end else if (count_q != '0 && cur_q.timestamp_us <= last_time_q) begin
						out_q   <= summary_beat(10'(count_q), 1'b0, '0, '0, ST_TIME_REJ);
						out_v_q <= 1'b1;
						ret_q   <= IDLE;
						state_q <= WAIT;
					end else if (32'(count_q) >= 32'(mis_q) && (!has_chk_q ||
						32'(count_q - last_chk_q) >= 32'(ci_q))) begin
						has_chk_q  <= 1'b1;
						last_chk_q <= count_q;
						chk_q      <= 1'b1;
						state_q    <= RAD;
					end else begin
						state_q <= SUM;
					end
				end
				RAD: state_q <= RADW;
				RADW: begin
					rad2_q  <= mul_p[47:0];
					i_q     <= '0;
					state_q <= (count_q == '0) ? SEL_INIT : G_RD;
				end
				G_RD: state_q <= G_DIF;
				G_DIF: begin
					dx_q <= cx - hx;
					dy_q <= cy - hy;
					hd_q <= dz_c[24] ? 25'(-dz_c) : 25'(dz_c);
					elig_ok_q <= (32'(id_gap) >= 32'(mis_q)) && (t_gap >= {16'd0, mts_q});
					state_q <= G_MX;
				end
				G_MX: state_q <= G_MY;
				G_MY: begin
					pd_q    <= mul_p;
					state_q <= G_ACC;
				end
				G_ACC: begin
					pd_q    <= pd_q + mul_p;
					state_q <= G_WR;
				end
				G_WR: begin
					if (elig_ok_q) begin
						elig_q <= elig_q + 1'b1;
					end
					if (near_c) begin
						near_q <= near_q + 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == count_q) ? SEL_INIT : G_RD;
				end
				SEL_INIT: begin
					npick_q     <= '0;
					have_last_q <= 1'b0;
					if (mc_q == 5'd0) begin
						limit_q <= PW'(1);
					end else if (32'(mc_q) > MAX_PICKS) begin
						limit_q <= PW'(MAX_PICKS);
					end else begin
						limit_q <= PW'(mc_q);
					end
					state_q <= S_START;
				end
				S_START: begin
					i_q     <= '0;
					found_q <= 1'b0;
					v_s1    <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (i_q != count_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= i_q[AW-1:0];
						i_q    <= i_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (take) begin
						found_q <= 1'b1;
						best_q  <= idx_s1;
						bd_q    <= d_s;
					end
					if (i_q == count_q && !v_s1) begin
						state_q <= found_q ? P_RD : SUM;
					end
				end
				P_RD: state_q <= P_DIF;
				P_DIF: begin
					dz_q    <= dz_c;
					hd_q    <= dz_c[24] ? 25'(-dz_c) : 25'(dz_c);
					tgap_q  <= t_gap;
					state_q <= P_MZ;
				end
				P_MZ: state_q <= P_OUT;
				P_OUT: begin
					out_q.kf_num             <= 10'(count_q);
					out_q.match_num          <= 10'(best_q);
					out_q.num_gap            <= 10'(count_q - IDW'(best_q));
					out_q.time_separation_us <= tgap_q;
					out_q.planar_distance_sq <= bd_q;
					out_q.z_gap              <= hd_q;
					out_q.translation_distance_sq <= bd_q + mul_p;
					out_q.checked            <= 1'b1;
					out_q.eligible_count     <= 11'(elig_q);
					out_q.nearby_count       <= 11'(near_q);
					out_q.status             <= ST_OK;
					out_q.last               <= 1'b0;
					out_v_q <= 1'b1;
					for (int k = 0; k < MAX_PICKS; k++) begin
						if (32'(k) == 32'(npick_q)) begin
							chosen_q[k] <= best_q;
						end
					end
					npick_q     <= npick_q + 1'b1;
					have_last_q <= 1'b1;
					last_d_q    <= bd_q;
					last_i_q    <= best_q;
					ret_q       <= (npick_q + 1'b1 == limit_q) ? SUM : S_START;
					state_q     <= WAIT;
				end
				SUM: begin
					out_q   <= summary_beat(10'(count_q), chk_q, 11'(elig_q), 11'(near_q),
						ST_OK);
					out_v_q <= 1'b1;
					ret_q   <= STORE;
					state_q <= WAIT;
				end
				WAIT: begin
					if (out_ready) begin
						out_v_q <= 1'b0;
						state_q <= ret_q;
					end
				end
				STORE: begin
					count_q     <= count_q + 1'b1;
					last_time_q <= cur_q.timestamp_us;
					state_q     <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- dv/loop_closure_candidate_selector_test.sv -----
// ----------------------------------------------------------------------------
// loop_closure_candidate_selector_test: self-checking bench for the selector
// A directed table (reset values, timestamp and position extremes, timestamp
// rejection, pick limit zero and saturated, zero separations) is followed by
// random keyframes clustered around anchor points under several register
// settings. Every result beat is checked against an in-bench model.
// ----------------------------------------------------------------------------
module loop_closure_candidate_selector_test;
	import lccs_pkg::*;

	localparam int HDEPTH = HISTORY_DEPTH_DEF;
	localparam int NPICKS = MAX_PICKS_DEF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] val;
		in_t         kf;
		bit          typed;
		out_t        want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	loop_closure_candidate_selector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// model state
	logic [9:0]  r_interval = 10'd1;
	logic [9:0]  r_min_id = 10'd50;
	logic [31:0] r_min_time = 32'd30000000;
	logic [23:0] r_max_planar = 24'd10240;
	logic [23:0] r_max_height = 24'd2048;
	logic [9:0]  r_cand_sep = 10'd10;
	logic [4:0]  r_max_cand = 5'd1;

	logic [47:0] kf_ts [HDEPTH];
	longint      kf_x [HDEPTH];
	longint      kf_y [HDEPTH];
	longint      kf_z [HDEPTH];
	bit          kf_near [HDEPTH];
	int unsigned kf_count = 0;
	bit          searched_once = 0;
	int unsigned last_searched = 0;
	int unsigned picked [NPICKS];

	out_t        pending_results [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          calm = 0;
	int          stall_left = 0;
	logic [47:0] tb_ts = '0;
	logic [23:0] anchor_x [4];
	logic [23:0] anchor_y [4];
	logic [23:0] anchor_z [4];
	row_t        table_rows [$];

	function automatic out_t make_result(int unsigned id, int unsigned cand, logic [47:0] tsep,
			longint pd, longint hd, longint td, bit chk, int unsigned elig,
			int unsigned nearc, logic [1:0] st, bit lst);
		out_t r;
		r.kf_num = id[9:0];
		r.match_num = cand[9:0];
		r.num_gap = lst ? 10'd0 : 10'(id - cand);
		r.time_separation_us = tsep;
		r.planar_distance_sq = pd[49:0];
		r.z_gap = hd[24:0];
		r.translation_distance_sq = td[49:0];
		r.checked = chk;
		r.eligible_count = elig[10:0];
		r.nearby_count = nearc[10:0];
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	function automatic void expect_beat(out_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic longint planar_sq(int unsigned i, longint x, longint y);
		longint dx, dy;
		dx = x - kf_x[i];
		dy = y - kf_y[i];
		return dx * dx + dy * dy;
	endfunction

	function automatic longint abs_diff(longint a, longint b);
		return a >= b ? a - b : b - a;
	endfunction

	function automatic void predict_keyframe(in_t kf);
		longint x, y, z, d, bd, last_d, rad2, dz;
		int unsigned id, elig, nearc, npick, limit, best, last_i, gap;
		bit found, sup, have_last;
		x = longint'(kf.pos_x);
		y = longint'(kf.pos_y);
		z = longint'(kf.pos_z);
		id = kf_count;
		elig = 0;
		nearc = 0;
		npick = 0;
		have_last = 0;
		last_d = 0;
		last_i = 0;
		rad2 = longint'(r_max_planar) * longint'(r_max_planar);
		if (kf_count >= HDEPTH) begin
			expect_beat(make_result(id, 0, 0, 0, 0, 0, 0, 0, 0, ST_FULL_REJ, 1));
			return;
		end
		if (kf_count > 0 && kf.timestamp_us <= kf_ts[kf_count - 1]) begin
			expect_beat(make_result(id, 0, 0, 0, 0, 0, 0, 0, 0, ST_TIME_REJ, 1));
			return;
		end
		if (id >= r_min_id && (!searched_once || id - last_searched >= r_interval)) begin
			searched_once = 1;
			last_searched = id;
			for (int unsigned i = 0; i < kf_count; i++) begin
				kf_near[i] = 0;
				if (id - i < r_min_id || 48'(kf.timestamp_us - kf_ts[i]) < r_min_time)
					continue;
				elig++;
				if (planar_sq(i, x, y) > rad2 || abs_diff(z, kf_z[i]) > longint'(r_max_height))
					continue;
				nearc++;
				kf_near[i] = 1;
			end
			limit = (r_max_cand == 0) ? 1 : r_max_cand;
			if (limit > NPICKS)
				limit = NPICKS;
			while (npick < limit) begin
				found = 0;
				best = 0;
				bd = 0;
				for (int unsigned i = 0; i < kf_count; i++) begin
					if (!kf_near[i])
						continue;
					d = planar_sq(i, x, y);
					if (have_last && (d < last_d || (d == last_d && i <= last_i)))
						continue;
					sup = 0;
					for (int unsigned k = 0; k < npick; k++) begin
						gap = picked[k] > i ? picked[k] - i : i - picked[k];
						if (gap < r_cand_sep)
							sup = 1;
					end
					if (sup)
						continue;
					if (!found || d < bd) begin
						found = 1;
						best = i;
						bd = d;
					end
				end
				if (!found)
					break;
				dz = z - kf_z[best];
				expect_beat(make_result(id, best,
					48'(kf.timestamp_us - kf_ts[best]), bd, abs_diff(z, kf_z[best]),
					bd + dz * dz, 1, elig, nearc, ST_OK, 0));
				picked[npick] = best;
				npick++;
				have_last = 1;
				last_d = bd;
				last_i = best;
			end
			expect_beat(make_result(id, 0, 0, 0, 0, 0, 1, elig, nearc, ST_OK, 1));
		end else begin
			expect_beat(make_result(id, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 1));
		end
		kf_ts[id] = kf.timestamp_us;
		kf_x[id] = x;
		kf_y[id] = y;
		kf_z[id] = z;
		kf_count = id + 1;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			CFG_CHECK_INTERVAL: r_interval = val[9:0];
			CFG_MIN_ID_SEP:     r_min_id = val[9:0];
			CFG_MIN_TIME_SEP:   r_min_time = val;
			CFG_MAX_PLANAR:     r_max_planar = val[23:0];
			CFG_MAX_HEIGHT:     r_max_height = val[23:0];
			CFG_MIN_CAND_SEP:   r_cand_sep = val[9:0];
			CFG_MAX_CANDIDATES: r_max_cand = val[4:0];
			default: ;
		endcase
	endfunction

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic in_t rand_keyframe();
		in_t k;
		int r, a;
		r = $urandom_range(0, 99);
		a = $urandom_range(0, 3);
		if (r < 6) begin
			k.timestamp_us = tb_ts - 48'($urandom_range(0, 3));
		end else begin
			if (r < 14)
				tb_ts = tb_ts + 48'({$urandom, $urandom} & 64'h3_FFFF_FFFF);
			else
				tb_ts = tb_ts + 48'($urandom_range(1, 5000));
			k.timestamp_us = tb_ts;
		end
		if (r >= 90) begin
			k.pos_x = 24'($urandom);
			k.pos_y = 24'($urandom);
			k.pos_z = 24'($urandom);
		end else begin
			k.pos_x = anchor_x[a] + 24'($urandom_range(0, 2000)) - 24'd1000;
			k.pos_y = anchor_y[a] + 24'($urandom_range(0, 2000)) - 24'd1000;
			k.pos_z = anchor_z[a] + 24'($urandom_range(0, 600)) - 24'd300;
		end
		return k;
	endfunction

	task automatic send_keyframe(in_t kf);
		int g;
		g = next_gap();
		cfg_valid <= 1'b0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_data <= kf;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_keyframe(kf);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
	endtask

	task automatic set_regs(logic [31:0] ci, logic [31:0] mis, logic [31:0] mts,
			logic [31:0] mpd, logic [31:0] mhd, logic [31:0] mcs, logic [31:0] mc);
		wait_idle();
		write_reg(CFG_CHECK_INTERVAL, ci);
		write_reg(CFG_MIN_ID_SEP, mis);
		write_reg(CFG_MIN_TIME_SEP, mts);
		write_reg(CFG_MAX_PLANAR, mpd);
		write_reg(CFG_MAX_HEIGHT, mhd);
		write_reg(CFG_MIN_CAND_SEP, mcs);
		write_reg(CFG_MAX_CANDIDATES, mc);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_beat(logic [47:0] ts, logic [23:0] x, logic [23:0] y,
			logic [23:0] z, bit typed, int unsigned id, logic [1:0] st);
		row_t r;
		r.kind = ROW_BEAT;
		r.idx = '0;
		r.val = '0;
		r.kf = '{ts, x, y, z};
		r.typed = typed;
		r.want = make_result(id, 0, 0, 0, 0, 0, 0, 0, 0, st, 1);
		table_rows.insert(table_rows.size(), r);
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
		row_t r;
		r = '{ROW_CFG, idx, val, '0, 0, '0};
		table_rows.insert(table_rows.size(), r);
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_idle();
			if ((i % 8) == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_keyframe(rand_keyframe());
		end
		calm = 0;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("loop_closure_candidate_selector test failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		out_t want;
		int r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat %h", out_data);
				end else begin
					want = pending_results.pop_front();
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch kf %0d: match exp %0d got %0d, status exp %0d got %0d, last exp %0d got %0d",
								want.kf_num, want.match_num, out_data.match_num,
								want.status, out_data.status, want.last, out_data.last);
							$display("  exp %h", want);
							$display("  got %h", out_data);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (!calm && r < 20)
					stall_left = (r < 3) ? $urandom_range(20, 80) : $urandom_range(1, 3);
			end
		end
	end

	initial begin
		bit prev_cfg;
		row_t row;

		// directed table, ids as assigned under reset settings
		add_beat(48'd0, 24'd0, 24'd0, 24'd0, 1, 0, ST_OK);
		add_beat(48'd0, 24'd1, 24'd1, 24'd1, 1, 1, ST_TIME_REJ);
		add_beat(48'd1000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1, 1, ST_OK);
		add_beat(48'd999, 24'd0, 24'd0, 24'd0, 1, 2, ST_TIME_REJ);
		add_beat(48'd2000, 24'h800000, 24'h7FFFFF, 24'h800000, 1, 2, ST_OK);
		add_beat(48'd3000, 24'd10, -24'sd10, 24'd0, 1, 3, ST_OK);
		add_cfg(CFG_CHECK_INTERVAL, 32'd0);
		add_cfg(CFG_MIN_ID_SEP, 32'd1);
		add_cfg(CFG_MIN_TIME_SEP, 32'd0);
		add_cfg(CFG_MAX_PLANAR, 32'hFFFFFF);
		add_cfg(CFG_MAX_HEIGHT, 32'hFFFFFF);
		add_cfg(CFG_MIN_CAND_SEP, 32'd0);
		add_cfg(CFG_MAX_CANDIDATES, 32'd0);
		add_beat(48'd4000, 24'd0, 24'd0, 24'd0, 0, 0, ST_OK);
		add_cfg(CFG_MAX_CANDIDATES, 32'd31);
		add_cfg(CFG_MIN_CAND_SEP, 32'd1);
		add_cfg(CFG_UNUSED, 32'hFFFFFFFF);
		add_beat(48'd5000, 24'd5, 24'd5, 24'd5, 0, 0, ST_OK);
		add_beat(48'd6000, 24'd0, 24'd0, 24'd0, 0, 0, ST_OK);
		add_cfg(CFG_MAX_PLANAR, 32'd1);
		add_cfg(CFG_MAX_HEIGHT, 32'd0);
		add_cfg(CFG_MIN_CAND_SEP, 32'd2);
		add_cfg(CFG_MIN_TIME_SEP, 32'd1500);
		add_beat(48'd7000, 24'd0, 24'd0, 24'd0, 0, 0, ST_OK);
		add_beat(48'd7000, 24'd3, 24'd3, 24'd3, 1, 8, ST_TIME_REJ);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_cfg = 0;
		foreach (table_rows[i]) begin
			row = table_rows[i];
			if (row.kind == ROW_CFG) begin
				if (!prev_cfg)
					wait_idle();
				write_reg(row.idx, row.val);
				prev_cfg = 1;
			end else begin
				send_keyframe(row.kf);
				if (row.typed)
					pending_results[$] = row.want;
				prev_cfg = 0;
			end
		end
		tb_ts = 48'd8000;

		// fixed and random settings, clustered positions so searches find neighbors
		for (int p = 0; p < 4; p++) begin
			for (int a = 0; a < 4; a++) begin
				anchor_x[a] = 24'($urandom);
				anchor_y[a] = 24'($urandom);
				anchor_z[a] = 24'($urandom);
			end
			case (p)
				0: set_regs(1, 5, 0, 4000, 2000, 3, 16);
				1: begin
					anchor_x[0] = 24'h7FFFFF; anchor_y[0] = 24'h800000;
					anchor_x[1] = 24'h800000; anchor_y[1] = 24'h7FFFFF;
					set_regs(0, 1, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 31);
				end
				2: set_regs($urandom_range(1, 4), $urandom_range(1, 20),
					$urandom_range(0, 2000), $urandom_range(1, 24'hFFFFFF),
					$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 15), 0);
				default: set_regs($urandom_range(1, 3), $urandom_range(1, 10),
					32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, $urandom_range(1, 8),
					$urandom_range(2, 16));
			endcase
			random_phase(25);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("loop_closure_candidate_selector test passed");
		else
			$display("loop_closure_candidate_selector test failed");
		$finish;
	end

endmodule
